// ===== rtl/core/manhattan_transform_stack_macros.svh =====
// Assertion helpers used by the port checker of this block.
`ifndef MANHATTAN_TRANSFORM_STACK_MACROS_SVH
`define MANHATTAN_TRANSFORM_STACK_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

  typedef enum logic [2:0] {
    CmdIdentity  = 3'd0,
    CmdPush      = 3'd1,
    CmdPop       = 3'd2,
    CmdOrient    = 3'd3,
    CmdTranslate = 3'd4,
    CmdMap       = 3'd5,
    CmdInvMap    = 3'd6,
    CmdOrientMap = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StBottom = 2'd2
  } status_e;

  localparam logic [2:0] OriNone     = 3'd0;
  localparam logic [2:0] OriMirrorX  = 3'd1;
  localparam logic [2:0] OriMirrorY  = 3'd2;
  localparam logic [2:0] OriRot90    = 3'd3;
  localparam logic [2:0] OriRot180   = 3'd4;
  localparam logic [2:0] OriRot270   = 3'd5;
  localparam logic [2:0] OriMxRot90  = 3'd6;
  localparam logic [2:0] OriMyRot90  = 3'd7;

  typedef struct packed {
    logic [2:0]  orient;
    logic [31:0] tx;
    logic [31:0] ty;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  // Coefficients m00, m01, m10, m11 per orientation.
  localparam logic signed [1:0] MatTab [8][4] = '{
    '{ 1,  0,  0,  1},
    '{-1,  0,  0,  1},
    '{ 1,  0,  0, -1},
    '{ 0, -1,  1,  0},
    '{-1,  0,  0, -1},
    '{ 0,  1, -1,  0},
    '{ 0, -1, -1,  0},
    '{ 0,  1,  1,  0}
  };

  // Indexed by {after, top, op}.
  localparam logic [2:0] ComposeTab [128] = '{
    0,1,2,3,4,5,6,7,
    1,0,4,7,2,6,5,3,
    2,4,0,6,1,7,3,5,
    3,6,7,4,5,0,2,1,
    4,2,1,5,0,3,7,6,
    5,7,6,0,3,4,1,2,
    6,3,5,1,7,2,0,4,
    7,5,3,2,6,1,4,0,
    0,1,2,3,4,5,6,7,
    1,0,4,6,2,7,3,5,
    2,4,0,7,1,6,5,3,
    3,7,6,4,5,0,1,2,
    4,2,1,5,0,3,7,6,
    5,6,7,0,3,4,2,1,
    6,5,3,2,7,1,0,4,
    7,3,5,1,6,2,4,0
  };

  function automatic logic [31:0] coef_mul(logic signed [1:0] c, logic [31:0] v);
    logic [31:0] r;
    unique case (c)
      2'sb01:  r = v;
      2'sb11:  r = 32'd0 - v;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Returns {rx, ry}; transposed matrix when tr is set. One term per row is zero.
  function automatic logic [63:0] mat_apply(logic [2:0] o, logic tr,
                                            logic [31:0] x, logic [31:0] y);
    logic [31:0] rx;
    logic [31:0] ry;
    if (tr) begin
      rx = coef_mul(MatTab[o][0], x) | coef_mul(MatTab[o][2], y);
      ry = coef_mul(MatTab[o][1], x) | coef_mul(MatTab[o][3], y);
    end else begin
      rx = coef_mul(MatTab[o][0], x) | coef_mul(MatTab[o][1], y);
      ry = coef_mul(MatTab[o][2], x) | coef_mul(MatTab[o][3], y);
    end
    return {rx, ry};
  endfunction

  function automatic logic is_mirror(logic [2:0] o);
    return (o == OriMirrorX) || (o == OriMirrorY) ||
           (o == OriMxRot90) || (o == OriMyRot90);
  endfunction

endpackage

// ===== rtl/core/mts_ram.sv =====
module mts_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mts_exec.sv =====
module mts_exec #(
  parameter int STACK_DEPTH = 16,
  localparam int LevelW = $clog2(STACK_DEPTH)
) (
  input  mts_pkg::cmd_e      cmd_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        y_i,
  input  logic [2:0]         op_i,
  input  logic               after_i,
  input  mts_pkg::entry_t    top_i,
  input  mts_pkg::entry_t    under_i,
  input  logic [LevelW-1:0]  level_i,
  output mts_pkg::entry_t    top_o,
  output logic [LevelW-1:0]  level_o,
  output mts_pkg::stack_op_t stack_op_o,
  output mts_pkg::status_e   status_o,
  output logic [31:0]        out_x_o,
  output logic [31:0]        out_y_o
);
  import mts_pkg::*;

  localparam logic [LevelW-1:0] LevelFull = LevelW'(STACK_DEPTH - 1);

  logic [63:0] fwd_xy;
  logic [63:0] inv_xy;
  logic [63:0] rot_t;

  assign fwd_xy = mat_apply(top_i.orient, 1'b0, x_i, y_i);
  assign inv_xy = mat_apply(top_i.orient, 1'b1, x_i - top_i.tx, y_i - top_i.ty);
  assign rot_t  = mat_apply(op_i, 1'b0, top_i.tx, top_i.ty);

  always_comb begin
    top_o      = top_i;
    level_o    = level_i;
    stack_op_o = '0;
    status_o   = StOk;
    out_x_o    = x_i;
    out_y_o    = y_i;
    unique case (cmd_i)
      CmdIdentity: begin
        top_o = '{orient: OriNone, tx: 32'd0, ty: 32'd0};
      end
      CmdPush: begin
        if (level_i == LevelFull) begin
          status_o = StFull;
        end else begin
          stack_op_o.push = 1'b1;
          level_o         = level_i + LevelW'(1);
        end
      end
      CmdPop: begin
        if (level_i == '0) begin
          status_o = StBottom;
        end else begin
          stack_op_o.pop = 1'b1;
          level_o        = level_i - LevelW'(1);
          top_o          = under_i;
        end
      end
      CmdOrient: begin
        top_o.orient = ComposeTab[{after_i, top_i.orient, op_i}];
        if (after_i) begin
          top_o.tx = rot_t[63:32];
          top_o.ty = rot_t[31:0];
        end
      end
      CmdTranslate: begin
        if (after_i) begin
          top_o.tx = top_i.tx + x_i;
          top_o.ty = top_i.ty + y_i;
        end else begin
          top_o.tx = fwd_xy[63:32] + top_i.tx;
          top_o.ty = fwd_xy[31:0] + top_i.ty;
        end
      end
      CmdMap: begin
        out_x_o = fwd_xy[63:32] + top_i.tx;
        out_y_o = fwd_xy[31:0] + top_i.ty;
      end
      CmdInvMap: begin
        out_x_o = inv_xy[63:32];
        out_y_o = inv_xy[31:0];
      end
      CmdOrientMap: begin
        out_x_o = fwd_xy[63:32];
        out_y_o = fwd_xy[31:0];
      end
    endcase
  end

endmodule

// ===== rtl/core/manhattan_transform_stack.sv =====
// Channel  Handshake                      Payload
// in       in_valid_i / in_stall_o        command, in_x, in_y, orient_op, apply_after
// out      out_valid_o / out_stall_i      out_x, out_y, top_orient, is_mirrored, depth, status
//
// One command per cycle while out_stall_i is low; a command passes the input register, then the result register.
// Input register, one pass of command logic, result register.
// The top entry and the one below it live in flops; deeper entries sit in a RAM
// whose registered read always tracks the entry under those two.
// rst_ni clears the top to identity and the stack to a single entry.
// A stalled result holds the pipe; in_stall_o rises only when both stages are full.
module manhattan_transform_stack #(
  parameter int STACK_DEPTH = 16,
  localparam int DepthW = $clog2(STACK_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic [2:0]        orient_op_i,
  input  logic              apply_after_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [2:0]        top_orient_o,
  output logic              is_mirrored_o,
  output logic [DepthW-1:0] depth_o,
  output logic [1:0]        status_o
);
  import mts_pkg::*;

  localparam int LevelW   = $clog2(STACK_DEPTH);
  localparam int MemDepth = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic              in_vld_q;
  logic [2:0]        cmd_q;
  logic [31:0]       x_q;
  logic [31:0]       y_q;
  logic [2:0]        op_q;
  logic              after_q;

  entry_t            top_q, top_d;
  entry_t            under_q;
  logic [LevelW-1:0] level_q, level_d, level_nxt;
  stack_op_t         stack_op;
  status_e           status_d;
  logic [31:0]       res_x_d, res_y_d;

  logic              out_vld_q;
  logic [31:0]       out_x_q, out_y_q;
  logic [2:0]        orient_q;
  logic              mirror_q;
  logic [DepthW-1:0] depth_q;
  logic [1:0]        status_q;

  logic              fire;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [EntryW-1:0] mem_rdata;
  logic              hit_q;
  entry_t            wdata_q;
  entry_t            mem_entry;

  assign fire       = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !fire;

  mts_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
    .cmd_i      (cmd_e'(cmd_q)),
    .x_i        (x_q),
    .y_i        (y_q),
    .op_i       (op_q),
    .after_i    (after_q),
    .top_i      (top_q),
    .under_i    (under_q),
    .level_i    (level_q),
    .top_o      (top_d),
    .level_o    (level_d),
    .stack_op_o (stack_op),
    .status_o   (status_d),
    .out_x_o    (res_x_d),
    .out_y_o    (res_y_d)
  );

  // Spill the under entry to RAM on push; prefetch the next under entry every cycle.
  assign mem_we    = fire && stack_op.push && (level_q != '0);
  assign mem_waddr = AddrW'(level_q - LevelW'(1));
  assign level_nxt = fire ? level_d : level_q;
  assign mem_raddr = AddrW'(level_nxt - LevelW'(2));
  assign mem_entry = hit_q ? wdata_q : entry_t'(mem_rdata);

  mts_ram #(.Width(EntryW), .Depth(MemDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (under_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      level_q   <= '0;
      top_q     <= '{orient: OriNone, tx: 32'd0, ty: 32'd0};
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        top_q     <= top_d;
        level_q   <= level_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      hit_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      cmd_q   <= command_i;
      x_q     <= in_x_i;
      y_q     <= in_y_i;
      op_q    <= orient_op_i;
      after_q <= apply_after_i;
    end
    if (fire) begin
      out_x_q  <= res_x_d;
      out_y_q  <= res_y_d;
      orient_q <= top_d.orient;
      mirror_q <= is_mirror(top_d.orient);
      depth_q  <= DepthW'(level_d) + DepthW'(1);
      status_q <= status_d;
      if (stack_op.push) begin
        under_q <= top_q;
      end else if (stack_op.pop) begin
        under_q <= mem_entry;
      end
    end
    wdata_q <= under_q;
  end

  assign out_valid_o   = out_vld_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign top_orient_o  = orient_q;
  assign is_mirrored_o = mirror_q;
  assign depth_o       = depth_q;
  assign status_o      = status_q;

endmodule

// ===== rtl/core/mts_checker.sv =====
`include "manhattan_transform_stack_macros.svh"

module mts_port_checker #(
  parameter int STACK_DEPTH = 16,
  localparam int DepthW = $clog2(STACK_DEPTH + 1)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [31:0]       out_x_o,
  input logic [2:0]        top_orient_o,
  input logic              is_mirrored_o,
  input logic [DepthW-1:0] depth_o,
  input logic [1:0]        status_o
);
  import mts_pkg::*;

  logic mirror_code;
  logic full_out;
  logic bottom_out;

  assign mirror_code = (top_orient_o == OriMirrorX) || (top_orient_o == OriMirrorY) ||
                       (top_orient_o == OriMxRot90) || (top_orient_o == OriMyRot90);
  assign full_out    = out_valid_o && (status_o == StFull);
  assign bottom_out  = out_valid_o && (status_o == StBottom);

  `MTS_ASSERT_NOW(a_mirror_flag, clk_i, rst_ni, out_valid_o, is_mirrored_o == mirror_code)
  `MTS_ASSERT_NOW(a_full_depth, clk_i, rst_ni, full_out, depth_o == DepthW'(STACK_DEPTH))
  `MTS_ASSERT_NOW(a_bottom_depth, clk_i, rst_ni, bottom_out, depth_o == DepthW'(1))
  `MTS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_x_o) && $stable(depth_o))

endmodule

bind manhattan_transform_stack mts_port_checker #(.STACK_DEPTH(STACK_DEPTH)) u_mts_port_checker (.*);

// ===== dv/mts_checker.sv =====
`timescale 1ns / 1ps

module mts_checker
  import mts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [2:0]  orient_op_i,
  input  logic        apply_after_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] out_x_i,
  input  logic [31:0] out_y_i,
  input  logic [2:0]  top_orient_i,
  input  logic        is_mirrored_i,
  input  logic [4:0]  depth_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          refused_o
);

  localparam int StackDepth = 16;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [2:0]  orient;
    logic        mirrored;
    logic [4:0]  depth;
    status_e     status;
  } transform_result_t;

  transform_result_t result_q[$];

  logic [2:0]  top_orient;
  logic [31:0] top_tx;
  logic [31:0] top_ty;
  logic [2:0]  saved_orient [StackDepth-1];
  logic [31:0] saved_tx [StackDepth-1];
  logic [31:0] saved_ty [StackDepth-1];
  int          level;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    checked_o = 0;
    refused_o = 0;
  end

  function automatic int coef(logic [2:0] o, int idx);
    int m[4];
    case (o)
      OriNone:    m = '{ 1,  0,  0,  1};
      OriMirrorX: m = '{-1,  0,  0,  1};
      OriMirrorY: m = '{ 1,  0,  0, -1};
      OriRot90:   m = '{ 0, -1,  1,  0};
      OriRot180:  m = '{-1,  0,  0, -1};
      OriRot270:  m = '{ 0,  1, -1,  0};
      OriMxRot90: m = '{ 0, -1, -1,  0};
      default:    m = '{ 0,  1,  1,  0};
    endcase
    return m[idx];
  endfunction

  function automatic logic [31:0] scale(int c, logic [31:0] v);
    if (c > 0) return v;
    if (c < 0) return 32'd0 - v;
    return 32'd0;
  endfunction

  // {rx, ry} = M(o) * (x, y), or the transpose of M(o) when tr is set
  function automatic logic [63:0] turn(logic [2:0] o, logic tr, logic [31:0] x,
                                       logic [31:0] y);
    int a;
    int b;
    int c;
    int d;
    a = coef(o, 0);
    b = tr ? coef(o, 2) : coef(o, 1);
    c = tr ? coef(o, 1) : coef(o, 2);
    d = coef(o, 3);
    return {scale(a, x) + scale(b, y), scale(c, x) + scale(d, y)};
  endfunction

  // code of the product M(lhs) * M(rhs)
  function automatic logic [2:0] combine(logic [2:0] lhs, logic [2:0] rhs);
    int p[4];
    logic [2:0] code;
    p[0] = coef(lhs, 0) * coef(rhs, 0) + coef(lhs, 1) * coef(rhs, 2);
    p[1] = coef(lhs, 0) * coef(rhs, 1) + coef(lhs, 1) * coef(rhs, 3);
    p[2] = coef(lhs, 2) * coef(rhs, 0) + coef(lhs, 3) * coef(rhs, 2);
    p[3] = coef(lhs, 2) * coef(rhs, 1) + coef(lhs, 3) * coef(rhs, 3);
    code = OriNone;
    for (int k = 0; k < 8; k++) begin
      if (coef(k[2:0], 0) == p[0] && coef(k[2:0], 1) == p[1] &&
          coef(k[2:0], 2) == p[2] && coef(k[2:0], 3) == p[3]) begin
        code = k[2:0];
      end
    end
    return code;
  endfunction

  function automatic logic flips(logic [2:0] o);
    return (coef(o, 0) * coef(o, 3) - coef(o, 1) * coef(o, 2)) < 0;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic predict_transfer();
    transform_result_t r;
    logic [63:0] v;
    r.x = in_x_i;
    r.y = in_y_i;
    r.status = StOk;
    case (cmd_e'(command_i))
      CmdIdentity: begin
        top_orient = OriNone;
        top_tx = '0;
        top_ty = '0;
      end
      CmdPush: begin
        if (level >= StackDepth - 1) begin
          r.status = StFull;
        end else begin
          saved_orient[level] = top_orient;
          saved_tx[level] = top_tx;
          saved_ty[level] = top_ty;
          level++;
        end
      end
      CmdPop: begin
        if (level == 0) begin
          r.status = StBottom;
        end else begin
          level--;
          top_orient = saved_orient[level];
          top_tx = saved_tx[level];
          top_ty = saved_ty[level];
        end
      end
      CmdOrient: begin
        if (apply_after_i) begin
          top_orient = combine(orient_op_i, top_orient);
          {top_tx, top_ty} = turn(orient_op_i, 1'b0, top_tx, top_ty);
        end else begin
          top_orient = combine(top_orient, orient_op_i);
        end
      end
      CmdTranslate: begin
        if (apply_after_i) begin
          top_tx = top_tx + in_x_i;
          top_ty = top_ty + in_y_i;
        end else begin
          v = turn(top_orient, 1'b0, in_x_i, in_y_i);
          top_tx = v[63:32] + top_tx;
          top_ty = v[31:0] + top_ty;
        end
      end
      CmdMap: begin
        v = turn(top_orient, 1'b0, in_x_i, in_y_i);
        r.x = v[63:32] + top_tx;
        r.y = v[31:0] + top_ty;
      end
      CmdInvMap: begin
        {r.x, r.y} = turn(top_orient, 1'b1, in_x_i - top_tx, in_y_i - top_ty);
      end
      default: begin
        {r.x, r.y} = turn(top_orient, 1'b0, in_x_i, in_y_i);
      end
    endcase
    r.orient = top_orient;
    r.mirrored = flips(top_orient);
    r.depth = 5'(level + 1);
    if (r.status != StOk) refused_o++;
    result_q.push_back(r);
  endtask

  task automatic compare_transfer();
    transform_result_t r;
    if (result_q.size() == 0) begin
      note_mismatch("result with nothing pending", out_x_i, '0);
    end else begin
      r = result_q.pop_front();
      if (out_x_i !== r.x) note_mismatch("out_x", out_x_i, r.x);
      if (out_y_i !== r.y) note_mismatch("out_y", out_y_i, r.y);
      if (top_orient_i !== r.orient) note_mismatch("top_orient", top_orient_i, r.orient);
      if (is_mirrored_i !== r.mirrored) note_mismatch("is_mirrored", is_mirrored_i, r.mirrored);
      if (depth_i !== r.depth) note_mismatch("depth", depth_i, r.depth);
      if (status_i !== r.status) note_mismatch("status", status_i, r.status);
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_orient = OriNone;
      top_tx = '0;
      top_ty = '0;
      level = 0;
      result_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_transfer();
      if (in_valid_i && !in_stall_i) predict_transfer();
      pending_o = result_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mts_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CmdIdentity;
  logic [31:0] in_x = '0;
  logic [31:0] in_y = '0;
  logic [2:0]  orient_op = OriNone;
  logic        apply_after = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [2:0]  top_orient;
  logic        is_mirrored;
  logic [4:0]  depth;
  logic [1:0]  status;

  int fails;
  int pending;
  int checked;
  int refused;
  int send_idle = 12;
  int recv_idle = 53;
  bit hold_req = 1'b0;
  bit in_acc = 1'b0;
  int quiet = 0;
  int sent = 0;

  manhattan_transform_stack dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (cmd),
    .in_x_i       (in_x),
    .in_y_i       (in_y),
    .orient_op_i  (orient_op),
    .apply_after_i(apply_after),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .top_orient_o (top_orient),
    .is_mirrored_o(is_mirrored),
    .depth_o      (depth),
    .status_o     (status)
  );

  mts_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (cmd),
    .in_x_i       (in_x),
    .in_y_i       (in_y),
    .orient_op_i  (orient_op),
    .apply_after_i(apply_after),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_x_i      (out_x),
    .out_y_i      (out_y),
    .top_orient_i (top_orient),
    .is_mirrored_i(is_mirrored),
    .depth_i      (depth),
    .status_i     (status),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .refused_o    (refused)
  );

  always #1 clk = ~clk;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_acc <= 1'b0;
      quiet <= 0;
    end else begin
      in_acc <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("timeout after %0d quiet cycles, %0d results pending", quiet, pending);
        $display("tb: failure");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle);
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5: return 32'($urandom_range(200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(cmd_e c, logic [31:0] x, logic [31:0] y, logic [2:0] op,
                      logic after);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    cmd = c;
    in_x = x;
    in_y = y;
    orient_op = op;
    apply_after = after;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_acc);
    sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_edit();
    if ($urandom_range(1)) begin
      send(CmdOrient, rand_word(), rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
    end else begin
      send(CmdTranslate, rand_word(), rand_word(), 3'($urandom_range(7)),
           1'($urandom_range(1)));
    end
  endtask

  task automatic send_mixed();
    int pick;
    cmd_e c;
    pick = $urandom_range(99);
    if (pick < 12) c = CmdPush;
    else if (pick < 24) c = CmdPop;
    else if (pick < 40) c = CmdOrient;
    else if (pick < 55) c = CmdTranslate;
    else if (pick < 70) c = CmdMap;
    else if (pick < 82) c = CmdInvMap;
    else if (pick < 93) c = CmdOrientMap;
    else c = CmdIdentity;
    send(c, rand_word(), rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  // fill to full depth or past it, then unwind to the bottom or past it
  task automatic fill_and_unwind();
    repeat ($urandom_range(15, 18)) begin
      send(CmdPush, rand_word(), rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
      if ($urandom_range(1)) send_edit();
    end
    repeat ($urandom_range(15, 18)) begin
      send(CmdPop, rand_word(), rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
      send(CmdMap, rand_word(), rand_word(), 3'($urandom_range(7)), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_run(int n_items);
    int stop;
    int pick;
    stop = sent + n_items;
    while (sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        fill_and_unwind();
      end else if (pick < 20) begin
        send(cmd_e'($urandom_range(7)), $urandom, $urandom, 3'($urandom_range(7)),
             1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(4, 12)) send_mixed();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(CmdPop, 32'h7fff_ffff, 32'h8000_0000, OriNone, 1'b0);
    send(CmdMap, 32'h7fff_ffff, 32'h8000_0000, OriNone, 1'b0);
    send(CmdTranslate, 32'h7fff_ffff, 32'h8000_0000, OriNone, 1'b1);
    send(CmdTranslate, 32'h0000_0001, 32'hffff_ffff, OriNone, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send(CmdOrient, '0, '0, 3'(k), 1'(k % 2));
    end
    send(CmdOrient, '0, '0, OriMxRot90, 1'b0);
    send(CmdTranslate, 32'h8000_0000, 32'h7fff_ffff, OriMyRot90, 1'b0);
    send(CmdMap, 32'h8000_0000, 32'h8000_0000, OriNone, 1'b0);
    send(CmdInvMap, 32'h8000_0000, 32'h7fff_ffff, OriNone, 1'b0);
    send(CmdOrientMap, 32'h8000_0000, 32'hffff_ffff, OriNone, 1'b1);
    send(CmdPush, '1, '1, 3'b111, 1'b1);
    send(CmdOrient, '1, '1, OriRot90, 1'b1);
    send(CmdPop, '1, '1, OriNone, 1'b1);
    send(CmdIdentity, '1, '1, 3'b111, 1'b1);
    send(CmdMap, '1, '1, 3'b111, 1'b1);
    drain();

    random_run(600);
    hold_req = 1'b1;
    random_run(40);
    drain();

    send_idle = 53;
    recv_idle = 12;
    random_run(600);
    drain();

    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    random_run(660);

    drain();
    repeat (10) @(negedge clk);

    $display("summary: %0d commands sent, %0d results compared, %0d refused push/pop",
             sent, checked, refused);
    $display("summary: full and empty stack edges, all orientations and wrapping, long holds");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
